/* rtl/core/dns_response_address_extractor_unit_assert.svh */
// assertion macros used by the core parser module
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_UNIT_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DRAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dras_pkg.sv */
package dras_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_LABEL  = 3'd2,
    PH_PTR    = 3'd3,
    PH_QFIX   = 3'd4,
    PH_AFIX   = 3'd5,
    PH_RDATA  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_NOTOURS = 3'd1,
    ST_SHORT   = 3'd2,
    ST_NONAME  = 3'd3,
    ST_FAIL    = 3'd4
  } status_t;

  localparam logic [7:0] LABEL_MASK   = 8'hC0;
  localparam logic [7:0] QR_MASK      = 8'h80;
  localparam logic [7:0] RCODE_MASK   = 8'h0F;
  localparam logic [7:0] RCODE_NXNAME = 8'h03;
  localparam logic [3:0] HEADER_LAST  = 4'd11;
  localparam logic [3:0] QFIX_LAST    = 4'd3;
  localparam logic [3:0] AFIX_LAST    = 4'd9;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] CLASS_IN    = 16'd1;
  localparam logic [15:0] ADDR_LEN    = 16'd4;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       is_last;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
  } result_t;

endpackage

/* rtl/core/dras_byte_if.sv */
interface dras_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] resp_byte;
  logic       is_last;

  modport source (output valid, output resp_byte, output is_last, input ready);
  modport sink (input valid, input resp_byte, input is_last, output ready);
endinterface

/* rtl/core/dras_result_if.sv */
interface dras_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] address;

  modport source (output valid, output status, output address, input ready);
  modport sink (input valid, input status, input address, output ready);
endinterface

/* rtl/core/dras_cfg_if.sv */
interface dras_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] expected_id;

  modport source (output valid, output expected_id, input ready);
  modport sink (input valid, input expected_id, output ready);
endinterface

/* rtl/core/dns_response_address_extractor_unit.sv */
// channel  | dir | payload                   | notes
// request  | in  | resp_byte[7:0], is_last   | one datagram byte per request
// result   | out | status[2:0], address[31:0]| one result per datagram
// cfg      | in  | expected_id[15:0]         | always ready
//
// one byte a cycle sustained while results are taken; a byte waits in the input register
// until taken, and a final byte's result is loaded into the output register as it is taken
// a full result register is the only cause of a stall: a final byte waits
// in the input register while an earlier result is still not taken
// rst is synchronous and clears the parser state, the id register and both valids
module dns_response_address_extractor_unit (
  input  logic          clk,
  input  logic          rst,
  dras_byte_if.sink     request,
  dras_result_if.source result,
  dras_cfg_if.sink      cfg
);
  import dras_pkg::*;

  logic       in_full;
  logic       out_free;
  logic       take;
  logic       res_fire;
  byte_item_t item;
  result_t    res;

  assign cfg.ready = 1'b1;
  assign take      = in_full && (!item.is_last || out_free);

  dras_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .take    (take),
    .full    (in_full),
    .item    (item)
  );

  dras_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_id   (cfg.expected_id),
    .step     (take),
    .item     (item),
    .res_fire (res_fire),
    .res      (res)
  );

  dras_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_fire),
    .res    (res),
    .free   (out_free),
    .result (result)
  );
endmodule

/* rtl/core/dras_in_stage.sv */
module dras_in_stage (
  input  logic                clk,
  input  logic                rst,
  dras_byte_if.sink           request,
  input  logic                take,
  output logic                full,
  output dras_pkg::byte_item_t item
);
  import dras_pkg::*;

  assign request.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (request.valid && request.ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      item.resp_byte <= request.resp_byte;
      item.is_last   <= request.is_last;
    end
  end
endmodule

/* rtl/core/dras_parser.sv */
`include "dns_response_address_extractor_unit_assert.svh"

module dras_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_id,
  input  logic                 step,
  input  dras_pkg::byte_item_t item,
  output logic                 res_fire,
  output dras_pkg::result_t    res
);
  import dras_pkg::*;

  logic [15:0] expected_id;
  phase_t      phase, phase_next;
  logic [3:0]  field_index, field_index_next;
  status_t     header_flags_bad, header_flags_bad_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] record_class, record_class_next;
  logic [15:0] record_data_len, record_data_len_next;
  logic [31:0] address_acc, address_acc_next;
  logic        decided, decided_next;

  logic        do_name_done, do_start_answers, do_record_done, do_decide;
  status_t     decide_st;
  status_t     final_st;
  logic [7:0]  b;

  assign b = item.resp_byte;
  assign res_fire = step && item.is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 16'd0;
    end else if (cfg_we) begin
      expected_id <= cfg_id;
    end
  end

  always_comb begin
    phase_next            = phase;
    field_index_next      = field_index;
    header_flags_bad_next = header_flags_bad;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    skip_left_next        = skip_left;
    record_type_next      = record_type;
    record_class_next     = record_class;
    record_data_len_next  = record_data_len;
    address_acc_next      = address_acc;
    decided_next          = decided;
    do_name_done          = 1'b0;
    do_start_answers      = 1'b0;
    do_record_done        = 1'b0;
    do_decide             = 1'b0;
    decide_st             = ST_FOUND;
    final_st              = ST_FAIL;
    res.status            = 3'd0;
    res.address           = 32'd0;

    if (step && !decided) begin
      unique case (phase)
        PH_HEADER: begin
          unique case (field_index)
            4'd0: begin
              if (b != expected_id[15:8] && header_flags_bad_next == ST_FOUND) begin
                header_flags_bad_next = ST_NOTOURS;
              end
            end
            4'd1: begin
              if (b != expected_id[7:0] && header_flags_bad_next == ST_FOUND) begin
                header_flags_bad_next = ST_NOTOURS;
              end
            end
            4'd2: begin
              if ((b & QR_MASK) == 8'd0 && header_flags_bad_next == ST_FOUND) begin
                header_flags_bad_next = ST_NOTOURS;
              end
            end
            4'd3: begin
              if (header_flags_bad_next == ST_FOUND) begin
                if ((b & RCODE_MASK) == RCODE_NXNAME) begin
                  header_flags_bad_next = ST_NONAME;
                end else if ((b & RCODE_MASK) != 8'd0) begin
                  header_flags_bad_next = ST_FAIL;
                end
              end
            end
            4'd4: questions_left_next = {b, 8'd0};
            4'd5: questions_left_next = {questions_left[15:8], b};
            4'd6: answers_left_next = {b, 8'd0};
            4'd7: answers_left_next = {answers_left[15:8], b};
            default: ;
          endcase
          field_index_next = field_index + 4'd1;
          if (field_index == HEADER_LAST) begin
            field_index_next = 4'd0;
            if (header_flags_bad_next != ST_FOUND) begin
              do_decide = 1'b1;
              decide_st = header_flags_bad_next;
            end else if (questions_left_next != 16'd0) begin
              phase_next = PH_NAME;
            end else begin
              do_start_answers = 1'b1;
            end
          end
        end
        PH_NAME: begin
          if ((b & LABEL_MASK) == LABEL_MASK) begin
            phase_next = PH_PTR;
          end else if ((b & LABEL_MASK) != 8'd0) begin
            do_decide = 1'b1;
            decide_st = ST_FAIL;
          end else if (b == 8'd0) begin
            do_name_done = 1'b1;
          end else begin
            skip_left_next = {8'd0, b};
            phase_next     = PH_LABEL;
          end
        end
        PH_LABEL: begin
          skip_left_next = skip_left - 16'd1;
          if (skip_left_next == 16'd0) begin
            phase_next = PH_NAME;
          end
        end
        PH_PTR: do_name_done = 1'b1;
        PH_QFIX: begin
          field_index_next = field_index + 4'd1;
          if (field_index == QFIX_LAST) begin
            field_index_next    = 4'd0;
            questions_left_next = questions_left - 16'd1;
            if (questions_left_next != 16'd0) begin
              phase_next = PH_NAME;
            end else begin
              do_start_answers = 1'b1;
            end
          end
        end
        PH_AFIX: begin
          unique case (field_index)
            4'd0: record_type_next = {b, 8'd0};
            4'd1: record_type_next = {record_type[15:8], b};
            4'd2: record_class_next = {b, 8'd0};
            4'd3: record_class_next = {record_class[15:8], b};
            4'd8: record_data_len_next = {b, 8'd0};
            4'd9: record_data_len_next = {record_data_len[15:8], b};
            default: ;
          endcase
          field_index_next = field_index + 4'd1;
          if (field_index == AFIX_LAST) begin
            field_index_next = 4'd0;
            address_acc_next = 32'd0;
            skip_left_next   = record_data_len_next;
            if (record_data_len_next == 16'd0) begin
              do_record_done = 1'b1;
            end else begin
              phase_next = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          address_acc_next = {address_acc[23:0], b};
          skip_left_next   = skip_left - 16'd1;
          if (skip_left_next == 16'd0) begin
            do_record_done = 1'b1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      if (do_name_done) begin
        field_index_next = 4'd0;
        phase_next = (questions_left != 16'd0) ? PH_QFIX : PH_AFIX;
      end
      if (do_start_answers) begin
        if (answers_left_next == 16'd0) begin
          do_decide = 1'b1;
          decide_st = ST_NONAME;
        end else begin
          phase_next = PH_NAME;
        end
      end
      if (do_record_done) begin
        if (record_type_next == TYPE_A && record_class_next == CLASS_IN &&
            record_data_len_next == ADDR_LEN) begin
          do_decide = 1'b1;
          decide_st = ST_FOUND;
        end else begin
          answers_left_next = answers_left - 16'd1;
          if (answers_left_next == 16'd0) begin
            do_decide = 1'b1;
            decide_st = ST_NONAME;
          end else begin
            phase_next = PH_NAME;
          end
        end
      end
      if (do_decide) begin
        header_flags_bad_next = decide_st;
        decided_next          = 1'b1;
        phase_next            = PH_DONE;
      end
    end

    if (decided_next) begin
      final_st = header_flags_bad_next;
    end else if (phase_next == PH_HEADER) begin
      final_st = ST_SHORT;
    end else begin
      final_st = ST_FAIL;
    end
    res.status  = final_st;
    res.address = (final_st == ST_FOUND) ? address_acc_next : 32'd0;

    // end of datagram: back to the start
    if (res_fire) begin
      phase_next            = PH_HEADER;
      field_index_next      = 4'd0;
      header_flags_bad_next = ST_FOUND;
      questions_left_next   = 16'd0;
      answers_left_next     = 16'd0;
      skip_left_next        = 16'd0;
      record_type_next      = 16'd0;
      record_class_next     = 16'd0;
      record_data_len_next  = 16'd0;
      address_acc_next      = 32'd0;
      decided_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      field_index      <= 4'd0;
      header_flags_bad <= ST_FOUND;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      skip_left        <= 16'd0;
      record_type      <= 16'd0;
      record_class     <= 16'd0;
      record_data_len  <= 16'd0;
      address_acc      <= 32'd0;
      decided          <= 1'b0;
    end else begin
      phase            <= phase_next;
      field_index      <= field_index_next;
      header_flags_bad <= header_flags_bad_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      skip_left        <= skip_left_next;
      record_type      <= record_type_next;
      record_class     <= record_class_next;
      record_data_len  <= record_data_len_next;
      address_acc      <= address_acc_next;
      decided          <= decided_next;
    end
  end

  `DRAS_ASSERT_NOW(a_decided_done, decided, phase == PH_DONE, "decided outside done phase")
  `DRAS_ASSERT_NEXT(a_clear_after_last, res_fire, (phase == PH_HEADER) && !decided && (field_index == 4'd0), "state not cleared after last byte")
  `DRAS_ASSERT_NOW(a_addr_only_found, res_fire && (res.status != ST_FOUND), res.address == 32'd0, "address on a failed result")
  `DRAS_ASSERT_NOW(a_status_range, res_fire, res.status <= ST_FAIL, "status code out of range")
endmodule

/* rtl/core/dras_out_reg.sv */
module dras_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dras_pkg::result_t res,
  output logic              free,
  dras_result_if.source     result
);
  import dras_pkg::*;

  logic    valid;
  result_t data;

  assign free           = !valid || result.ready;
  assign result.valid   = valid;
  assign result.status  = data.status;
  assign result.address = data.address;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end
endmodule
